// File: rtl/lsks_pkg.sv
// ----------------------------------------------------------------------------
// lsks_pkg: shared types and constants of the loop sensor Kalman smoother
// Field widths, fixed-point scale factors and the word passed between
// the measurement front end and the filter back end.
// ----------------------------------------------------------------------------
package lsks_pkg;

  localparam int unsigned ADC_W   = 10;  // raw converter count
  localparam int unsigned NOISE_W = 16;  // Q0.16 noise registers
  localparam int unsigned PRESS_W = 20;  // Q4.16 pressure
  localparam int unsigned VAR_W   = 18;  // Q2.16 variance
  localparam int unsigned K_W     = 16;  // Q0.16 gain
  localparam int unsigned Z_FRAC  = 16;  // fraction bits of the pressure

  // Measurement scaling: z = (adc*50000 - 40920*R) * 2^16 / (16368*R)
  localparam int unsigned ADC_GAIN    = 50000;
  localparam int unsigned OFF_PER_OHM = 40920;
  localparam int unsigned DEN_PER_OHM = 16368;
  localparam int unsigned NUM_W       = 26;  // holds 1023 * 50000
  localparam int unsigned ZQ_W        = 21;  // unclamped quotient of the scaling

  localparam logic [PRESS_W-1:0] PRESS_MAX = 20'd655360;
  localparam logic [VAR_W-1:0]   VAR_MAX   = 18'd262143;
  localparam logic [VAR_W-1:0]   VAR_ONE   = 18'd65536;
  localparam logic [K_W:0]       ONE_Q16   = 17'd65536;
  localparam logic [NOISE_W-1:0] Q_RESET   = 16'd655;
  localparam logic [NOISE_W-1:0] R_RESET   = 16'd6554;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PROCESS_NOISE = 1'b0,
    CFG_MEASURE_NOISE = 1'b1
  } cfg_idx_t;

  // One converted measurement word between front and back
  typedef struct packed {
    logic               valid;
    logic [PRESS_W-1:0] z;
  } zword_t;

endpackage

// File: rtl/lsks_front.sv
// ----------------------------------------------------------------------------
// lsks_front: sample intake and pressure conversion
// Takes one ADC word, scales it to bar in Q4.16 by a reciprocal multiply
// for the constant shunt denominator with one correction step, clamps it
// and queues it.
// ----------------------------------------------------------------------------
module lsks_front import lsks_pkg::*; #(
  parameter int unsigned SHUNT_OHMS = 220
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ADC_W-1:0] adc,
  input  logic             adc_valid,
  output logic             adc_ready,
  output zword_t           push,
  input  logic             q_full
);

  // A zero shunt reads as zero pressure; the guarded divisor keeps the
  // constants below well defined in that case.
  localparam bit              ZERO_SHUNT = (SHUNT_OHMS == 0);
  localparam longint unsigned DEN        = (SHUNT_OHMS == 0) ? 64'd1 :
                                           64'(DEN_PER_OHM) * 64'(SHUNT_OHMS);
  localparam longint unsigned OFF        = 64'(OFF_PER_OHM) * 64'(SHUNT_OHMS);
  localparam longint unsigned HALF_DEN   = DEN / 2;
  localparam int unsigned     DIV_W      = NUM_W + Z_FRAC;
  localparam int unsigned     SPLIT      = DIV_W / 2;
  localparam int unsigned     HI_W       = DIV_W - SPLIT;
  // With floor(2^DIV_W / DEN) the quotient estimate is low by at most one.
  localparam longint unsigned RECIP      = (64'd1 << DIV_W) / DEN;
  localparam int unsigned     DEN_W      = $clog2(DEN + 1);
  localparam int unsigned     R_W        = DEN_W + 1;
  localparam int unsigned     M_W        = $clog2(RECIP + 1);
  localparam int unsigned     LP_W       = SPLIT + M_W;
  localparam int unsigned     HS_W       = HI_W + M_W + 1;

  localparam logic [R_W-1:0]   DEN_V    = R_W'(DEN);
  localparam logic [NUM_W-1:0] OFF_V    = NUM_W'(OFF);
  localparam logic [LP_W-1:0]  RECIP_LO = LP_W'(RECIP);
  localparam logic [HS_W-1:0]  RECIP_HI = HS_W'(RECIP);

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_MUL  = 7'b0000010,
    F_RLO  = 7'b0000100,
    F_RHI  = 7'b0001000,
    F_CORR = 7'b0010000,
    F_ADJ  = 7'b0100000,
    F_PUSH = 7'b1000000
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic [ADC_W-1:0]   adc_r, adc_nxt;
  logic [DIV_W-1:0]   n_r, n_nxt;
  logic [M_W-1:0]     lo_r, lo_nxt;
  logic [ZQ_W-1:0]    q0_r, q0_nxt;
  logic [R_W-1:0]     qm_r, qm_nxt;
  logic [ZQ_W-1:0]    qd_r, qd_nxt;

  logic [NUM_W-1:0]   prod;
  logic [NUM_W-1:0]   numv;
  logic [DIV_W-1:0]   dividend;
  logic [LP_W-1:0]    lo_prod;
  logic [HS_W-1:0]    hi_sum;
  logic [R_W-1:0]     rem;
  logic               ge;
  logic [PRESS_W-1:0] zq;

  assign prod     = NUM_W'(adc_r) * NUM_W'(ADC_GAIN);
  assign numv     = prod - OFF_V;
  assign dividend = {numv, Z_FRAC'(0)} + DIV_W'(HALF_DEN);
  // The dividend is split in two halves so each multiply stays narrow.
  assign lo_prod  = LP_W'(n_r[SPLIT-1:0]) * RECIP_LO;
  assign hi_sum   = HS_W'(n_r[DIV_W-1:SPLIT]) * RECIP_HI + HS_W'(lo_r);
  // The remainder is below twice the divisor, so its low bits suffice.
  assign rem      = n_r[R_W-1:0] - qm_r;
  assign ge       = (rem >= DEN_V);
  assign zq       = (qd_r > ZQ_W'(PRESS_MAX)) ? PRESS_MAX : qd_r[PRESS_W-1:0];

  assign adc_ready  = (state_r == F_IDLE);
  assign push.valid = (state_r == F_PUSH);
  assign push.z     = zq;

  always_comb begin
    state_nxt = state_r;
    adc_nxt   = adc_r;
    n_nxt     = n_r;
    lo_nxt    = lo_r;
    q0_nxt    = q0_r;
    qm_nxt    = qm_r;
    qd_nxt    = qd_r;
    unique case (state_r)
      F_IDLE: begin
        if (adc_valid) begin
          adc_nxt   = adc;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        // Currents at or below 4 mA read as zero pressure.
        if (ZERO_SHUNT || (prod <= OFF_V)) begin
          qd_nxt    = '0;
          state_nxt = F_PUSH;
        end else begin
          n_nxt     = dividend;
          state_nxt = F_RLO;
        end
      end
      F_RLO: begin
        lo_nxt    = lo_prod[LP_W-1:SPLIT];
        state_nxt = F_RHI;
      end
      F_RHI: begin
        q0_nxt    = ZQ_W'(hi_sum[HS_W-1:SPLIT]);
        state_nxt = F_CORR;
      end
      F_CORR: begin
        qm_nxt    = R_W'(q0_r) * DEN_V;
        state_nxt = F_ADJ;
      end
      F_ADJ: begin
        qd_nxt    = q0_r + ZQ_W'(ge);
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adc_r <= adc_nxt;
    n_r   <= n_nxt;
    lo_r  <= lo_nxt;
    q0_r  <= q0_nxt;
    qm_r  <= qm_nxt;
    qd_r  <= qd_nxt;
  end

endmodule

// File: rtl/lsks_queue.sv
// ----------------------------------------------------------------------------
// lsks_queue: two-entry measurement queue
// Decouples the conversion front end from the filter back end.
// ----------------------------------------------------------------------------
module lsks_queue import lsks_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  zword_t push,
  output logic   full,
  output zword_t head,
  input  logic   pop
);

  logic [PRESS_W-1:0] mem_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.z     = mem_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.z;
    end
  end

endmodule

// File: rtl/lsks_back.sv
// ----------------------------------------------------------------------------
// lsks_back: scalar Kalman update
// Pops one measurement, seeds or updates the estimate: serial gain divide,
// then one multiply each for the estimate and the variance, then output.
// ----------------------------------------------------------------------------
module lsks_back import lsks_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [NOISE_W-1:0] process_noise,
  input  logic [NOISE_W-1:0] measure_noise,
  input  zword_t             head,
  output logic               pop,
  output logic               out_valid,
  output logic [PRESS_W-1:0] out_data,
  input  logic               out_ready
);

  localparam int unsigned D_W   = VAR_W + 1;
  localparam int unsigned CNT_W = $clog2(K_W);
  localparam int unsigned PX_W  = K_W + PRESS_W;
  localparam int unsigned PP_W  = K_W + 1 + VAR_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(K_W - 1);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIV  = 5'b00010,
    B_MULX = 5'b00100,
    B_MULP = 5'b01000,
    B_FIN  = 5'b10000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  logic               seeded_r, seeded_nxt;
  logic [PRESS_W-1:0] x_r, x_nxt;
  logic [VAR_W-1:0]   p_r, p_nxt;
  logic [PRESS_W-1:0] z_r, z_nxt;
  logic [VAR_W-1:0]   pp_r, pp_nxt;
  logic [D_W-1:0]     d_r, d_nxt;
  logic [D_W-1:0]     rem_r, rem_nxt;
  logic [K_W-1:0]     qd_r, qd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               dir_r, dir_nxt;     // set when the estimate moves down
  logic [PX_W-1:0]    px_r, px_nxt;
  logic [PP_W-1:0]    ppr_r, ppr_nxt;
  logic               ov_r, ov_nxt;
  logic [PRESS_W-1:0] od_r, od_nxt;

  logic [D_W-1:0]     pq_sum;
  logic [VAR_W-1:0]   pp_sat;
  logic [NOISE_W-1:0] r_eff;
  logic [D_W:0]       trial;
  logic               ge;
  logic [PRESS_W-1:0] diff;
  logic [PX_W-1:0]    px_rnd;
  logic [PRESS_W-1:0] step;
  logic [PRESS_W-1:0] x_new;
  logic [K_W:0]       ik;
  logic [PP_W-1:0]    pp_rnd;
  logic [VAR_W:0]     p_full;
  logic [VAR_W-1:0]   p_new;
  logic               out_free;

  assign pq_sum = D_W'(p_r) + D_W'(process_noise);
  assign pp_sat = (pq_sum > D_W'(VAR_MAX)) ? VAR_MAX : pq_sum[VAR_W-1:0];
  assign r_eff  = (measure_noise == '0) ? NOISE_W'(1) : measure_noise;

  // The remainder stays below the divisor, so one bit more covers the trial.
  assign trial = {rem_r, qd_r[K_W-1]};
  assign ge    = (trial >= {1'b0, d_r});

  assign diff   = (z_r >= x_r) ? (z_r - x_r) : (x_r - z_r);
  assign px_rnd = px_r + PX_W'(32768);
  assign step   = px_rnd[PX_W-1:Z_FRAC];
  assign x_new  = dir_r ? (x_r - step) : (x_r + step);

  assign ik     = ONE_Q16 - {1'b0, qd_r};
  assign pp_rnd = ppr_r + PP_W'(32768);
  assign p_full = pp_rnd[PP_W-1:Z_FRAC];
  assign p_new  = (p_full > (VAR_W + 1)'(VAR_MAX)) ? VAR_MAX : p_full[VAR_W-1:0];

  assign out_free  = !ov_r || out_ready;
  assign pop       = (state_r == B_IDLE) && head.valid;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt  = state_r;
    seeded_nxt = seeded_r;
    x_nxt      = x_r;
    p_nxt      = p_r;
    z_nxt      = z_r;
    pp_nxt     = pp_r;
    d_nxt      = d_r;
    rem_nxt    = rem_r;
    qd_nxt     = qd_r;
    cnt_nxt    = cnt_r;
    dir_nxt    = dir_r;
    px_nxt     = px_r;
    ppr_nxt    = ppr_r;
    ov_nxt     = ov_r && !out_ready;
    od_nxt     = od_r;
    unique case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          if (!seeded_r) begin
            // The first sample only seeds the estimate.
            x_nxt      = head.z;
            seeded_nxt = 1'b1;
          end else begin
            z_nxt     = head.z;
            pp_nxt    = pp_sat;
            d_nxt     = D_W'(pp_sat) + D_W'(r_eff);
            rem_nxt   = D_W'(pp_sat);
            qd_nxt    = '0;
            cnt_nxt   = '0;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        rem_nxt = ge ? D_W'(trial - {1'b0, d_r}) : trial[D_W-1:0];
        qd_nxt  = {qd_r[K_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = B_MULX;
        end
      end
      B_MULX: begin
        px_nxt    = PX_W'(qd_r) * PX_W'(diff);
        dir_nxt   = (z_r < x_r);
        state_nxt = B_MULP;
      end
      B_MULP: begin
        ppr_nxt   = PP_W'(ik) * PP_W'(pp_r);
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (out_free) begin
          x_nxt     = x_new;
          p_nxt     = p_new;
          ov_nxt    = 1'b1;
          od_nxt    = x_new;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      seeded_r <= 1'b0;
      x_r      <= '0;
      p_r      <= VAR_ONE;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seeded_r <= seeded_nxt;
      x_r      <= x_nxt;
      p_r      <= p_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r   <= z_nxt;
    pp_r  <= pp_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    qd_r  <= qd_nxt;
    cnt_r <= cnt_nxt;
    dir_r <= dir_nxt;
    px_r  <= px_nxt;
    ppr_r <= ppr_nxt;
    od_r  <= od_nxt;
  end

endmodule

// File: rtl/loop_sensor_kalman_smoother_top.sv
// ----------------------------------------------------------------------------
// loop_sensor_kalman_smoother_top: 4-20 mA loop pressure Kalman smoother
//
//   channel  ports                       word contents
//   in       in_tvalid/tready/tdata      adc_sample [9:0]
//   out      out_tvalid/tready/tdata     filtered_pressure [19:0], Q4.16 bar
//   cfg      cfg_we/cfg_addr/cfg_wdata   0 process_noise, 1 measure_noise
//
// The front end converts one sample at a time. The filter update runs a
// 16-step serial gain divider and finishes one sample before it pops the
// next, and the two-entry queue lets the front run ahead. Reset is
// synchronous and active low; the first sample after it only seeds the
// estimate. A stalled output holds one word while the next is computed.
// ----------------------------------------------------------------------------
module loop_sensor_kalman_smoother_top import lsks_pkg::*; #(
  parameter int unsigned SHUNT_OHMS = 220
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,    // [9:0] adc_sample
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,   // [19:0] filtered_pressure
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  logic [NOISE_W-1:0] q_r, q_nxt;
  logic [NOISE_W-1:0] r_r, r_nxt;
  zword_t             push;
  zword_t             head;
  logic               q_full;
  logic               pop;
  logic [PRESS_W-1:0] out_data;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PROCESS_NOISE: q_nxt = cfg_wdata;
        CFG_MEASURE_NOISE: r_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= Q_RESET;
      r_r <= R_RESET;
    end else begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  lsks_front #(
    .SHUNT_OHMS(SHUNT_OHMS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adc      (in_tdata[ADC_W-1:0]),
    .adc_valid(in_tvalid),
    .adc_ready(in_tready),
    .push     (push),
    .q_full   (q_full)
  );

  lsks_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  lsks_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .process_noise(q_r),
    .measure_noise(r_r),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_data     (out_data),
    .out_ready    (out_tready)
  );

  assign out_tdata = {4'b0, out_data};

endmodule
